// ----- rtl/bmp24_stream_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// bmp24_stream_decoder_defines.svh
// Assertion macros shared by the decoder modules.
// ----------------------------------------------------------------------------
`ifndef BMP24_STREAM_DECODER_DEFINES_SVH
`define BMP24_STREAM_DECODER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, disabled in reset
`define BSD_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("bsd assertion failed");

// next-cycle implication, disabled in reset
`define BSD_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("bsd assertion failed");

`else

`define BSD_ASSERT_IMP(label, clk, rst_n, a, b)
`define BSD_ASSERT_NXT(label, clk, rst_n, a, b)

`endif

`endif

// ----- rtl/bsd_pkg.sv -----
// ----------------------------------------------------------------------------
// bsd_pkg
// Types and constants of the 24-bit BMP stream decoder.
// ----------------------------------------------------------------------------
package bsd_pkg;

  // word type at the input
  typedef enum logic [0:0] {
    OP_BYTE,
    OP_EOF
  } op_t;

  // header slot that a byte falls in, decided by the front
  typedef enum logic [3:0] {
    SLOT_NONE,
    SLOT_SIG_B,
    SLOT_SIG_M,
    SLOT_OFFSET,
    SLOT_WIDTH,
    SLOT_HEIGHT,
    SLOT_BPP,
    SLOT_COMP,
    SLOT_LAST
  } hdr_slot_t;

  // decoder phase
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  // classified word carried from front to back
  typedef struct packed {
    op_t         op;
    hdr_slot_t   slot;
    logic [1:0]  lane;
    logic [31:0] index;
    logic [7:0]  data;
  } q_entry_t;

  // result kinds
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR  = 3'd1;
  localparam logic [2:0] ST_BAD_SIG    = 3'd2;
  localparam logic [2:0] ST_UNSUPP     = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd4;
  localparam logic [2:0] ST_OFS_IN_HDR = 3'd5;
  localparam logic [2:0] ST_TRUNC      = 3'd6;

  // header layout
  localparam logic [31:0] HDR_LEN   = 32'd54;
  localparam logic [5:0]  IDX_SIG_B = 6'd0;
  localparam logic [5:0]  IDX_SIG_M = 6'd1;
  localparam logic [5:0]  OFS_BASE  = 6'd10;
  localparam logic [5:0]  WID_BASE  = 6'd18;
  localparam logic [5:0]  HGT_BASE  = 6'd22;
  localparam logic [5:0]  BPP_BASE  = 6'd28;
  localparam logic [5:0]  CMP_BASE  = 6'd30;
  localparam logic [5:0]  IDX_LAST  = 6'd53;

  localparam logic [7:0]  CHAR_B = 8'h42;
  localparam logic [7:0]  CHAR_M = 8'h4D;
  localparam logic [15:0] BPP_24 = 16'd24;

endpackage

// ----- rtl/bsd_channels.sv -----
// ----------------------------------------------------------------------------
// bsd_channels
// Valid/ready channels of the decoder: file words in, results out.
// ----------------------------------------------------------------------------
interface bsd_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface bsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [12:0] column;
  logic [12:0] row;
  logic [13:0] image_width;
  logic [13:0] image_height;
  logic [2:0]  status_code;

  modport source (
    output valid, output kind, output red, output green, output blue,
    output column, output row, output image_width, output image_height,
    output status_code, input ready
  );
  modport sink (
    input valid, input kind, input red, input green, input blue,
    input column, input row, input image_width, input image_height,
    input status_code, output ready
  );
endinterface

// ----- rtl/bsd_front.sv -----
// ----------------------------------------------------------------------------
// bsd_front
// Accepts file words, counts bytes and tags each with its header slot.
// ----------------------------------------------------------------------------
module bsd_front (
  input  logic              clk,
  input  logic              rst_n,
  bsd_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              push,
  output bsd_pkg::q_entry_t push_entry
);

  logic [31:0] cnt_r, cnt_nxt;
  logic [5:0]  idx;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  assign idx         = cnt_r[5:0];

  // classify the word
  always_comb begin
    push_entry.op    = in_ch.cmd ? bsd_pkg::OP_EOF : bsd_pkg::OP_BYTE;
    push_entry.index = cnt_r;
    push_entry.data  = in_ch.data_byte;
    push_entry.slot  = bsd_pkg::SLOT_NONE;
    push_entry.lane  = 2'd0;
    if (cnt_r < bsd_pkg::HDR_LEN) begin
      case (idx) inside
        bsd_pkg::IDX_SIG_B: push_entry.slot = bsd_pkg::SLOT_SIG_B;
        bsd_pkg::IDX_SIG_M: push_entry.slot = bsd_pkg::SLOT_SIG_M;
        [bsd_pkg::OFS_BASE : bsd_pkg::OFS_BASE + 6'd3]: begin
          push_entry.slot = bsd_pkg::SLOT_OFFSET;
          push_entry.lane = 2'(idx - bsd_pkg::OFS_BASE);
        end
        [bsd_pkg::WID_BASE : bsd_pkg::WID_BASE + 6'd3]: begin
          push_entry.slot = bsd_pkg::SLOT_WIDTH;
          push_entry.lane = 2'(idx - bsd_pkg::WID_BASE);
        end
        [bsd_pkg::HGT_BASE : bsd_pkg::HGT_BASE + 6'd3]: begin
          push_entry.slot = bsd_pkg::SLOT_HEIGHT;
          push_entry.lane = 2'(idx - bsd_pkg::HGT_BASE);
        end
        [bsd_pkg::BPP_BASE : bsd_pkg::BPP_BASE + 6'd1]: begin
          push_entry.slot = bsd_pkg::SLOT_BPP;
          push_entry.lane = 2'(idx - bsd_pkg::BPP_BASE);
        end
        [bsd_pkg::CMP_BASE : bsd_pkg::CMP_BASE + 6'd3]: begin
          push_entry.slot = bsd_pkg::SLOT_COMP;
          push_entry.lane = 2'(idx - bsd_pkg::CMP_BASE);
        end
        bsd_pkg::IDX_LAST: push_entry.slot = bsd_pkg::SLOT_LAST;
        default: push_entry.slot = bsd_pkg::SLOT_NONE;
      endcase
    end
  end

  // saturating byte count, cleared by end of file
  always_comb begin
    cnt_nxt = cnt_r;
    if (push) begin
      if (in_ch.cmd) begin
        cnt_nxt = 32'd0;
      end else if (cnt_r != 32'hFFFF_FFFF) begin
        cnt_nxt = cnt_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 32'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/bsd_queue.sv -----
// ----------------------------------------------------------------------------
// bsd_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
`include "bmp24_stream_decoder_defines.svh"

module bsd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bsd_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output bsd_pkg::q_entry_t pop_entry
);

  bsd_pkg::q_entry_t slots_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_entry = slots_r[rd_ptr_r];

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  `BSD_ASSERT_IMP(a_no_overflow, clk, rst_n, full, !push)
  `BSD_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, count_r != 2'd0)
  `BSD_ASSERT_IMP(a_ptrs_match_count, clk, rst_n, count_r == 2'd1, wr_ptr_r != rd_ptr_r)

endmodule

// ----- rtl/bsd_back.sv -----
// ----------------------------------------------------------------------------
// bsd_back
// Header check, offset skip and pixel assembly, one word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`include "bmp24_stream_decoder_defines.svh"

module bsd_back #(
  parameter int MAX_DIM = 8192
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  bsd_pkg::q_entry_t q_entry,
  output logic              pop,
  bsd_out_if.source         out_ch
);

  localparam logic [31:0] MaxDim32 = 32'(MAX_DIM);

  bsd_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [15:0] bpp_r, bpp_nxt;
  logic [31:0] comp_r, comp_nxt;
  logic        bottom_up_r, bottom_up_nxt;
  logic [12:0] row_r, row_nxt;
  logic [14:0] bir_r, bir_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [12:0] col_r, col_nxt;
  logic [7:0]  blue_r, blue_nxt;
  logic [7:0]  green_r, green_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [13:0] h_r, h_nxt;
  logic [14:0] w3_r, w3_nxt;
  logic [14:0] rowsz_r, rowsz_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  red_r, red_nxt;
  logic [7:0]  ogreen_r, ogreen_nxt;
  logic [7:0]  oblue_r, oblue_nxt;
  logic [12:0] ocol_r, ocol_nxt;
  logic [12:0] orow_r, orow_nxt;
  logic [13:0] owidth_r, owidth_nxt;
  logic [13:0] oheight_r, oheight_nxt;
  logic [2:0]  ostatus_r, ostatus_nxt;

  logic        do_pixel;
  logic [31:0] h_abs;
  logic [2:0]  chk;
  logic [15:0] w3_wide;
  logic [15:0] rowsz_wide;
  logic [13:0] dest_row;

  assign pop = q_valid && (!out_valid_r || out_ch.ready);

  // header derived values
  always_comb begin
    h_abs      = height_r[31] ? (32'd0 - height_r) : height_r;
    w3_wide    = {1'b0, width_r[13:0], 1'b0} + {2'b00, width_r[13:0]};
    rowsz_wide = (w3_wide + 16'd3) & ~16'd3;
    dest_row   = bottom_up_r ? (h_r - 14'd1 - {1'b0, row_r}) : {1'b0, row_r};
    chk        = status_r;
    if (status_r == bsd_pkg::ST_OK) begin
      if (bpp_r != bsd_pkg::BPP_24 || comp_r != 32'd0) begin
        chk = bsd_pkg::ST_UNSUPP;
      end else if (width_r == 32'd0 || width_r > MaxDim32 ||
                   h_abs == 32'd0 || h_abs > MaxDim32) begin
        chk = bsd_pkg::ST_BAD_SIZE;
      end else if (offset_r < bsd_pkg::HDR_LEN) begin
        chk = bsd_pkg::ST_OFS_IN_HDR;
      end
    end
  end

  // next state and result
  always_comb begin
    phase_nxt     = phase_r;
    offset_nxt    = offset_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    bpp_nxt       = bpp_r;
    comp_nxt      = comp_r;
    bottom_up_nxt = bottom_up_r;
    row_nxt       = row_r;
    bir_nxt       = bir_r;
    k_nxt         = k_r;
    col_nxt       = col_r;
    blue_nxt      = blue_r;
    green_nxt     = green_r;
    status_nxt    = status_r;
    h_nxt         = h_r;
    w3_nxt        = w3_r;
    rowsz_nxt     = rowsz_r;
    do_pixel      = 1'b0;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    kind_nxt      = kind_r;
    red_nxt       = red_r;
    ogreen_nxt    = ogreen_r;
    oblue_nxt     = oblue_r;
    ocol_nxt      = ocol_r;
    orow_nxt      = orow_r;
    owidth_nxt    = owidth_r;
    oheight_nxt   = oheight_r;
    ostatus_nxt   = ostatus_r;

    if (pop) begin
      // clear payload for a new result
      red_nxt     = 8'd0;
      ogreen_nxt  = 8'd0;
      oblue_nxt   = 8'd0;
      ocol_nxt    = 13'd0;
      orow_nxt    = 13'd0;
      owidth_nxt  = 14'd0;
      oheight_nxt = 14'd0;
      ostatus_nxt = 3'd0;
      out_valid_nxt = 1'b0;

      if (q_entry.op == bsd_pkg::OP_EOF) begin
        // end of file: report and return to reset state
        out_valid_nxt = 1'b1;
        kind_nxt      = bsd_pkg::KIND_STATUS;
        case (phase_r)
          bsd_pkg::PH_HEADER: ostatus_nxt = bsd_pkg::ST_SHORT_HDR;
          bsd_pkg::PH_DONE:   ostatus_nxt = status_r;
          default:            ostatus_nxt = bsd_pkg::ST_TRUNC;
        endcase
        phase_nxt     = bsd_pkg::PH_HEADER;
        offset_nxt    = 32'd0;
        width_nxt     = 32'd0;
        height_nxt    = 32'd0;
        bpp_nxt       = 16'd0;
        comp_nxt      = 32'd0;
        bottom_up_nxt = 1'b0;
        row_nxt       = 13'd0;
        bir_nxt       = 15'd0;
        k_nxt         = 2'd0;
        col_nxt       = 13'd0;
        blue_nxt      = 8'd0;
        green_nxt     = 8'd0;
        status_nxt    = bsd_pkg::ST_OK;
      end else begin
        case (phase_r)
          bsd_pkg::PH_HEADER: begin
            case (q_entry.slot)
              bsd_pkg::SLOT_SIG_B: begin
                if (q_entry.data != bsd_pkg::CHAR_B) status_nxt = bsd_pkg::ST_BAD_SIG;
              end
              bsd_pkg::SLOT_SIG_M: begin
                if (q_entry.data != bsd_pkg::CHAR_M) status_nxt = bsd_pkg::ST_BAD_SIG;
              end
              bsd_pkg::SLOT_OFFSET: offset_nxt[{q_entry.lane, 3'b000} +: 8] = q_entry.data;
              bsd_pkg::SLOT_WIDTH:  width_nxt[{q_entry.lane, 3'b000} +: 8]  = q_entry.data;
              bsd_pkg::SLOT_HEIGHT: height_nxt[{q_entry.lane, 3'b000} +: 8] = q_entry.data;
              bsd_pkg::SLOT_BPP:    bpp_nxt[{q_entry.lane[0], 3'b000} +: 8] = q_entry.data;
              bsd_pkg::SLOT_COMP:   comp_nxt[{q_entry.lane, 3'b000} +: 8]   = q_entry.data;
              bsd_pkg::SLOT_LAST: begin
                if (chk != bsd_pkg::ST_OK) begin
                  status_nxt = chk;
                  phase_nxt  = bsd_pkg::PH_DONE;
                end else begin
                  bottom_up_nxt = !height_r[31];
                  phase_nxt     = bsd_pkg::PH_SKIP;
                  h_nxt         = h_abs[13:0];
                  w3_nxt        = w3_wide[14:0];
                  rowsz_nxt     = rowsz_wide[14:0];
                  out_valid_nxt = 1'b1;
                  kind_nxt      = bsd_pkg::KIND_HEADER;
                  owidth_nxt    = width_r[13:0];
                  oheight_nxt   = h_abs[13:0];
                end
              end
              default: ;
            endcase
          end
          bsd_pkg::PH_SKIP: begin
            if (q_entry.index >= offset_r) begin
              phase_nxt = bsd_pkg::PH_PIXELS;
              do_pixel  = 1'b1;
            end
          end
          bsd_pkg::PH_PIXELS: do_pixel = 1'b1;
          default: ;
        endcase

        // pixel bytes: blue, green, red, then row padding
        if (do_pixel) begin
          if (bir_r < w3_r) begin
            case (k_r)
              2'd0: begin
                blue_nxt = q_entry.data;
                k_nxt    = 2'd1;
              end
              2'd1: begin
                green_nxt = q_entry.data;
                k_nxt     = 2'd2;
              end
              default: begin
                out_valid_nxt = 1'b1;
                kind_nxt      = bsd_pkg::KIND_PIXEL;
                red_nxt       = q_entry.data;
                ogreen_nxt    = green_r;
                oblue_nxt     = blue_r;
                ocol_nxt      = col_r;
                orow_nxt      = dest_row[12:0];
                k_nxt         = 2'd0;
                col_nxt       = col_r + 13'd1;
              end
            endcase
          end
          bir_nxt = bir_r + 15'd1;
          if ((bir_r + 15'd1) == rowsz_r) begin
            bir_nxt = 15'd0;
            k_nxt   = 2'd0;
            col_nxt = 13'd0;
            if (({1'b0, row_r} + 14'd1) == h_r) begin
              phase_nxt  = bsd_pkg::PH_DONE;
              status_nxt = bsd_pkg::ST_OK;
            end else begin
              row_nxt = row_r + 13'd1;
            end
          end
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= bsd_pkg::PH_HEADER;
      offset_r    <= 32'd0;
      width_r     <= 32'd0;
      height_r    <= 32'd0;
      bpp_r       <= 16'd0;
      comp_r      <= 32'd0;
      bottom_up_r <= 1'b0;
      row_r       <= 13'd0;
      bir_r       <= 15'd0;
      k_r         <= 2'd0;
      col_r       <= 13'd0;
      status_r    <= bsd_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      offset_r    <= offset_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      bpp_r       <= bpp_nxt;
      comp_r      <= comp_nxt;
      bottom_up_r <= bottom_up_nxt;
      row_r       <= row_nxt;
      bir_r       <= bir_nxt;
      k_r         <= k_nxt;
      col_r       <= col_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    blue_r    <= blue_nxt;
    green_r   <= green_nxt;
    h_r       <= h_nxt;
    w3_r      <= w3_nxt;
    rowsz_r   <= rowsz_nxt;
    kind_r    <= kind_nxt;
    red_r     <= red_nxt;
    ogreen_r  <= ogreen_nxt;
    oblue_r   <= oblue_nxt;
    ocol_r    <= ocol_nxt;
    orow_r    <= orow_nxt;
    owidth_r  <= owidth_nxt;
    oheight_r <= oheight_nxt;
    ostatus_r <= ostatus_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.red          = red_r;
  assign out_ch.green        = ogreen_r;
  assign out_ch.blue         = oblue_r;
  assign out_ch.column       = ocol_r;
  assign out_ch.row          = orow_r;
  assign out_ch.image_width  = owidth_r;
  assign out_ch.image_height = oheight_r;
  assign out_ch.status_code  = ostatus_r;

  `BSD_ASSERT_IMP(a_k_range, clk, rst_n, 1'b1, k_r != 2'd3)
  `BSD_ASSERT_IMP(a_bir_in_row, clk, rst_n, phase_r == bsd_pkg::PH_PIXELS, bir_r < rowsz_r)
  `BSD_ASSERT_IMP(a_row_in_image, clk, rst_n, phase_r == bsd_pkg::PH_PIXELS, {1'b0, row_r} < h_r)

endmodule

// ----- rtl/bmp24_stream_decoder.sv -----
// Path: an accepted file word is written into the queue, then decoded by the back part into its output registers.
// Throughput: one word per cycle while the output is not stalled.
// A stalled output holds its result while the two-entry queue takes words until it is full.
// Reset: synchronous, active-low rst_n; the decoder returns to header collection,
// the queue empties and no result is pending. End of file also returns the decoder to header collection.
// ----------------------------------------------------------------------------
// bmp24_stream_decoder
// Streaming decoder of uncompressed 24-bit BMP files: front, queue, back.
// ----------------------------------------------------------------------------
module bmp24_stream_decoder #(
  parameter int MAX_DIM = 8192
) (
  input  logic       clk,
  input  logic       rst_n,
  bsd_in_if.sink     in_ch,
  bsd_out_if.source  out_ch
);

  logic              push;
  logic              q_full;
  logic              pop;
  logic              q_valid;
  bsd_pkg::q_entry_t push_entry;
  bsd_pkg::q_entry_t q_entry;

  // accept and classify
  bsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue
  bsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry)
  );

  // decode and emit
  bsd_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
